[hw/rtl/color_blob_centroid_macros.svh]
// assertion macros shared by the checker
`ifndef COLOR_BLOB_CENTROID_MACROS_SVH
`define COLOR_BLOB_CENTROID_MACROS_SVH
`define CBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/cbc_pkg.sv]
// shared types and constants for the colour blob centroid block
package cbc_pkg;
	localparam int unsigned CountW = 17;
	localparam int unsigned SumW = 24;
	localparam int unsigned CenterW = 12;
	localparam logic [CountW-1:0] CountMax = '1;
	localparam logic [SumW-1:0] SumMax = '1;
	localparam logic [CenterW-1:0] CenterMax = '1;

	localparam logic [2:0] RegBright = 3'd0;
	localparam logic [2:0] RegChroma = 3'd1;
	localparam logic [2:0] RegHueLo = 3'd2;
	localparam logic [2:0] RegHueHi = 3'd3;
	localparam logic [2:0] RegMinCount = 3'd4;
	localparam logic [2:0] RegScale = 3'd5;

	typedef struct packed {
		logic [7:0] min_brightness;
		logic [7:0] min_chroma;
		logic [8:0] hue_lower;
		logic [8:0] hue_upper;
		logic [16:0] min_pixel_count;
		logic [4:0] scale_factor;
	} cfg_t;

	// one classified pixel handed from front to back
	typedef struct packed {
		logic hit;
		logic [7:0] col;
		logic [7:0] row;
		logic last;
	} cls_t;

	// 5 bit channel to 8 bit, truncating; ceil(2^20/31) stands in for 1/31
	function automatic logic [7:0] exp5(input logic [4:0] v);
		logic [12:0] p;
		logic [28:0] m;
		p = 13'(v) * 13'd255;
		m = 29'(p) * 29'd33826;
		return m[27:20];
	endfunction

	// 6 bit channel to 8 bit; ceil(2^20/63) stands in for 1/63
	function automatic logic [7:0] exp6(input logic [5:0] v);
		logic [13:0] p;
		logic [28:0] m;
		p = 14'(v) * 14'd255;
		m = 29'(p) * 29'd16645;
		return m[27:20];
	endfunction
endpackage

[hw/rtl/cbc_front.sv]
// front end: colour expansion, serial hue quotient and match test
module cbc_front #(
	parameter int unsigned MaxColumns = 256,
	parameter int unsigned MaxRows = 256
) (
	input logic clk,
	input logic arst_n,
	input cbc_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] pixel_value,
	input logic [7:0] column,
	input logic [7:0] row,
	input logic frame_last,
	output logic out_valid,
	input logic out_ready,
	output cbc_pkg::cls_t out_word
);
	import cbc_pkg::*;

	typedef enum logic [1:0] {DV_LOAD, DV_RUN, DV_DONE} dv_state_t;

	logic v_s1, v_s2;
	logic [7:0] r_s1, g_s1, b_s1, col_s1, row_s1;
	logic last_s1;
	cls_t word_s2;
	logic adv2, adv1, done;
	dv_state_t dv_q;
	logic [2:0] step_q;
	logic [8:0] rem_q;
	logic [5:0] nlo_q, quo_q;
	logic neg_q;

	assign done = v_s1 && (dv_q == DV_DONE);
	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || (done && adv2);
	assign in_ready = adv1;
	assign out_valid = v_s2;
	assign out_word = word_s2;

	logic [7:0] col_c, row_c;
	always_comb begin
		col_c = (32'(column) >= MaxColumns) ? 8'(MaxColumns - 1) : column;
		row_c = (32'(row) >= MaxRows) ? 8'(MaxRows - 1) : row;
	end

	// max, min, hue sector and band test on the stage 1 word
	logic [7:0] mx, mn, dl;
	logic signed [9:0] diff;
	logic [7:0] dmag;
	logic [13:0] mag;
	logic [8:0] trial;
	logic signed [10:0] quo;
	logic signed [10:0] h;
	logic [8:0] base;
	logic in_band, hit;
	always_comb begin
		mx = (r_s1 > g_s1) ? r_s1 : g_s1;
		mx = (mx > b_s1) ? mx : b_s1;
		mn = (r_s1 < g_s1) ? r_s1 : g_s1;
		mn = (mn < b_s1) ? mn : b_s1;
		dl = mx - mn;
		priority if (mx == r_s1) begin
			diff = 10'(g_s1) - 10'(b_s1);
			base = 9'd0;
		end else if (mx == g_s1) begin
			diff = 10'(b_s1) - 10'(r_s1);
			base = 9'd120;
		end else begin
			diff = 10'(r_s1) - 10'(g_s1);
			base = 9'd240;
		end
		dmag = diff[9] ? 8'(-diff) : diff[7:0];
		mag = 14'(dmag) * 14'd60;
		trial = {rem_q[7:0], nlo_q[5]};
		// magnitude quotient with the sign put back, so it truncates toward zero
		quo = neg_q ? -$signed({5'b0, quo_q}) : $signed({5'b0, quo_q});
		h = quo + $signed({2'b0, base});
		if (h < 0) h = h + 11'sd360;
		if (cfg.hue_lower <= cfg.hue_upper)
			in_band = (h >= $signed({2'b0, cfg.hue_lower}))
				&& (h <= $signed({2'b0, cfg.hue_upper}));
		else
			in_band = (h >= $signed({2'b0, cfg.hue_lower}))
				|| (h <= $signed({2'b0, cfg.hue_upper}));
		hit = (dl != 8'd0) && (mx >= cfg.min_brightness) && (dl >= cfg.min_chroma) && in_band;
	end

	// quotient is at most 60, so six restoring steps on the low numerator bits suffice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			dv_q <= DV_DONE;
			step_q <= '0;
			rem_q <= '0;
			nlo_q <= '0;
			quo_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= done;
			if (adv1 && in_valid) begin
				dv_q <= DV_LOAD;
			end else begin
				unique case (dv_q)
					DV_LOAD: begin
						rem_q <= {1'b0, mag[13:6]};
						nlo_q <= mag[5:0];
						quo_q <= '0;
						neg_q <= diff[9];
						step_q <= '0;
						dv_q <= DV_RUN;
					end
					DV_RUN: begin
						if (trial >= {1'b0, dl}) begin
							rem_q <= trial - {1'b0, dl};
							quo_q <= {quo_q[4:0], 1'b1};
						end else begin
							rem_q <= trial;
							quo_q <= {quo_q[4:0], 1'b0};
						end
						nlo_q <= {nlo_q[4:0], 1'b0};
						step_q <= step_q + 1'b1;
						if (step_q == 3'd5) dv_q <= DV_DONE;
					end
					DV_DONE: ;
					default: dv_q <= DV_DONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			r_s1 <= exp5(pixel_value[15:11]);
			g_s1 <= exp6(pixel_value[10:5]);
			b_s1 <= exp5(pixel_value[4:0]);
			col_s1 <= col_c;
			row_s1 <= row_c;
			last_s1 <= frame_last;
		end
		if (adv2 && done) begin
			word_s2 <= '{hit: hit, col: col_s1, row: row_s1, last: last_s1};
		end
	end
endmodule

[hw/rtl/cbc_fifo.sv]
// short word queue between front and back
module cbc_fifo #(
	parameter int unsigned Depth = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cbc_pkg::cls_t in_word,
	output logic out_valid,
	input logic out_ready,
	output cbc_pkg::cls_t out_word
);
	import cbc_pkg::*;
	localparam int unsigned AW = $clog2(Depth);

	cls_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (AW+1)'(Depth);
	assign out_valid = cnt_q != '0;
	assign out_word = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_word;
	end
endmodule

[hw/rtl/cbc_back.sv]
// back end: accumulators, and at frame end a multiply and, when a blob is found, a serial divide
module cbc_back (
	input logic clk,
	input logic arst_n,
	input cbc_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input cbc_pkg::cls_t in_word,
	output logic out_valid,
	input logic out_ready,
	output logic found,
	output logic [11:0] center_x,
	output logic [11:0] center_y,
	output logic [16:0] match_total
);
	import cbc_pkg::*;

	typedef enum logic [2:0] {ST_ACC, ST_MUL, ST_DIV, ST_OUT} state_t;
	state_t state_q;

	logic [CountW-1:0] cnt_q;
	logic [SumW-1:0] csum_q, rsum_q;
	logic [28:0] nx_q, ny_q;
	logic [28:0] qx_q, qy_q;
	logic [CountW:0] remx_q, remy_q;
	logic [4:0] step_q;
	logic fnd_q;

	assign in_ready = state_q == ST_ACC;

	// saturating adds for the incoming word
	logic [CountW:0] cnt_add;
	logic [SumW:0] cs_add, rs_add;
	logic [CountW-1:0] cnt_n;
	logic [SumW-1:0] cs_n, rs_n;
	always_comb begin
		cnt_add = {1'b0, cnt_q} + 1'b1;
		cs_add = {1'b0, csum_q} + (SumW+1)'(in_word.col);
		rs_add = {1'b0, rsum_q} + (SumW+1)'(in_word.row);
		cnt_n = cnt_q;
		cs_n = csum_q;
		rs_n = rsum_q;
		if (in_word.hit) begin
			cnt_n = cnt_add[CountW] ? CountMax : cnt_add[CountW-1:0];
			cs_n = cs_add[SumW] ? SumMax : cs_add[SumW-1:0];
			rs_n = rs_add[SumW] ? SumMax : rs_add[SumW-1:0];
		end
	end

	// restoring divide step, one quotient bit per cycle for both axes
	logic [CountW+1:0] tx, ty;
	always_comb begin
		tx = {remx_q, nx_q[28]};
		ty = {remy_q, ny_q[28]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			out_valid <= 1'b0;
			cnt_q <= '0;
			csum_q <= '0;
			rsum_q <= '0;
			step_q <= '0;
			fnd_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (in_valid) begin
						if (in_word.last) begin
							cnt_q <= cnt_n;
							csum_q <= cs_n;
							rsum_q <= rs_n;
							fnd_q <= (cnt_n != '0) && (cnt_n >= cfg.min_pixel_count);
							state_q <= ST_MUL;
						end else begin
							cnt_q <= cnt_n;
							csum_q <= cs_n;
							rsum_q <= rs_n;
						end
					end
				end
				ST_MUL: begin
					nx_q <= 29'(csum_q) * 29'(cfg.scale_factor);
					ny_q <= 29'(rsum_q) * 29'(cfg.scale_factor);
					remx_q <= '0;
					remy_q <= '0;
					step_q <= '0;
					state_q <= fnd_q ? ST_DIV : ST_OUT;
					if (!fnd_q) begin
						found <= 1'b0;
						match_total <= cnt_q;
						out_valid <= 1'b1;
					end
				end
				ST_DIV: begin
					nx_q <= {nx_q[27:0], 1'b0};
					ny_q <= {ny_q[27:0], 1'b0};
					if (tx >= (CountW+2)'(cnt_q)) begin
						remx_q <= (CountW+1)'(tx - (CountW+2)'(cnt_q));
						qx_q <= {qx_q[27:0], 1'b1};
					end else begin
						remx_q <= tx[CountW:0];
						qx_q <= {qx_q[27:0], 1'b0};
					end
					if (ty >= (CountW+2)'(cnt_q)) begin
						remy_q <= (CountW+1)'(ty - (CountW+2)'(cnt_q));
						qy_q <= {qy_q[27:0], 1'b1};
					end else begin
						remy_q <= ty[CountW:0];
						qy_q <= {qy_q[27:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 5'd28) begin
						state_q <= ST_OUT;
						out_valid <= 1'b1;
						found <= 1'b1;
						match_total <= cnt_q;
					end
				end
				ST_OUT: begin
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						cnt_q <= '0;
						csum_q <= '0;
						rsum_q <= '0;
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// centre saturation once the quotients settle
	always_comb begin
		center_x = '0;
		center_y = '0;
		if (fnd_q) begin
			center_x = (qx_q > 29'(CenterMax)) ? CenterMax : qx_q[CenterW-1:0];
			center_y = (qy_q > 29'(CenterMax)) ? CenterMax : qy_q[CenterW-1:0];
		end
	end
endmodule

[hw/rtl/color_blob_centroid.sv]
// top level of the colour blob centroid block
// Colour blob centroid: the front takes one RGB565 word at a time and holds off the
// next until that word's hue is done and its result can move on; after the word is
// registered, a load step forms the hue numerator and a one-bit-per-cycle divider gives
// the hue offset, then the classified word moves into a four-entry queue, and the back
// end adds matches into its accumulators. A frame-end word holds the back end (a
// multiply state; only when a blob is found, two one-bit-per-cycle dividers running side
// by side for the two centres; then offering the result word until the receiver takes
// it) before it takes the next word; the queue absorbs pixels meanwhile.
module color_blob_centroid #(
	parameter int unsigned MAX_COLUMNS = 256,
	parameter int unsigned MAX_ROWS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] pixel_value,
	input logic [7:0] column,
	input logic [7:0] row,
	input logic frame_last,
	output logic out_valid,
	input logic out_ready,
	output logic found,
	output logic [11:0] center_x,
	output logic [11:0] center_y,
	output logic [16:0] match_total
);
	import cbc_pkg::*;

	cfg_t cfg_q;
	logic [2:0] ridx;
	assign ridx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{min_brightness: 8'd80, min_chroma: 8'd25, hue_lower: 9'd300,
				hue_upper: 9'd12, min_pixel_count: 17'd18, scale_factor: 5'd8};
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				RegBright: cfg_q.min_brightness <= pwdata[7:0];
				RegChroma: cfg_q.min_chroma <= pwdata[7:0];
				RegHueLo: cfg_q.hue_lower <= pwdata[8:0];
				RegHueHi: cfg_q.hue_upper <= pwdata[8:0];
				RegMinCount: cfg_q.min_pixel_count <= pwdata[16:0];
				RegScale: cfg_q.scale_factor <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			RegBright: prdata = 32'(cfg_q.min_brightness);
			RegChroma: prdata = 32'(cfg_q.min_chroma);
			RegHueLo: prdata = 32'(cfg_q.hue_lower);
			RegHueHi: prdata = 32'(cfg_q.hue_upper);
			RegMinCount: prdata = 32'(cfg_q.min_pixel_count);
			RegScale: prdata = 32'(cfg_q.scale_factor);
			default: prdata = '0;
		endcase
	end

	logic f_v, f_r, q_v, q_r;
	cls_t f_w, q_w;

	cbc_front #(.MaxColumns(MAX_COLUMNS), .MaxRows(MAX_ROWS)) u_front (
		.clk, .arst_n, .cfg(cfg_q), .in_valid, .in_ready, .pixel_value, .column,
		.row, .frame_last, .out_valid(f_v), .out_ready(f_r), .out_word(f_w)
	);

	cbc_fifo #(.Depth(4)) u_fifo (
		.clk, .arst_n, .in_valid(f_v), .in_ready(f_r), .in_word(f_w),
		.out_valid(q_v), .out_ready(q_r), .out_word(q_w)
	);

	cbc_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .in_valid(q_v), .in_ready(q_r), .in_word(q_w),
		.out_valid, .out_ready, .found, .center_x, .center_y, .match_total
	);
endmodule

[hw/rtl/cbc_checker.sv]
// port-level checks for the colour blob centroid block
`include "color_blob_centroid_macros.svh"
module cbc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic [11:0] center_x,
	input logic [11:0] center_y,
	input logic [16:0] match_total
);
	`CBC_ASSERT_IMPL(a_nf_zero, clk, arst_n, out_valid && !found, center_x == 12'd0 && center_y == 12'd0)
	`CBC_ASSERT_IMPL(a_found_cnt, clk, arst_n, out_valid && found, match_total != 17'd0)
	`CBC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(match_total))
endmodule

bind color_blob_centroid cbc_checker u_cbc_checker (
	.clk, .arst_n, .out_valid, .out_ready, .found, .center_x, .center_y, .match_total
);
